// ----- rtl/utf8c_pkg.sv -----
// Package for the text payload checker: byte classes, second-byte rules,
// verdict codes and the classified item carried from front to back.
// No dependencies.
`default_nettype none

package utf8c_pkg;

    // Verdict codes on the result channel.
    localparam logic [1:0] VERDICT_CLEAN      = 2'd0;
    localparam logic [1:0] VERDICT_UTF8       = 2'd1;
    localparam logic [1:0] VERDICT_SUSPICIOUS = 2'd2;

    // Default depth of the queue between front and back.
    localparam int FIFO_DEPTH_DEFAULT = 2;

    // Class of one byte as seen outside a multibyte sequence.
    typedef enum logic [2:0] {
        CLS_TEXT,
        CLS_CR,
        CLS_NUL,
        CLS_LEAD,
        CLS_CONT,
        CLS_BAD
    } byte_class_t;

    // Extra limit on the byte that follows a lead byte.
    typedef enum logic [1:0] {
        RULE_NONE,
        RULE_MIN_A0,
        RULE_MIN_90,
        RULE_MAX_8F
    } second_rule_t;

    // One classified byte as queued between front and back.
    typedef struct packed {
        byte_class_t  cls;
        second_rule_t rule;
        logic [1:0]   lead_len;
        logic         ge_a0;
        logic         ge_90;
        logic         le_8f;
        logic         last;
    } class_item_t;

endpackage

`default_nettype wire

// ----- rtl/utf8c_if.sv -----
// Valid/ready channel interfaces for payload bytes and verdicts.
// No dependencies.
`default_nettype none

interface utf8c_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_payload;

    modport source (output valid, output text_byte, output end_of_payload, input ready);
    modport sink (input valid, input text_byte, input end_of_payload, output ready);
endinterface

interface utf8c_verdict_if;
    logic       valid;
    logic       ready;
    logic [1:0] verdict;

    modport source (output valid, output verdict, input ready);
    modport sink (input valid, input verdict, output ready);
endinterface

`default_nettype wire

// ----- rtl/utf8c_front.sv -----
// Front end of the checker: accepts payload bytes and classifies them.
// Depends on utf8c_pkg and utf8c_byte_if.
`default_nettype none

module utf8c_front (
    utf8c_byte_if.sink                bytes,
    input  wire logic                 full,
    output logic                      push,
    output utf8c_pkg::class_item_t    push_item
);

    logic [7:0] b;

    assign b             = bytes.text_byte;
    assign bytes.ready   = !full;
    assign push          = bytes.valid && !full;

    always_comb
    begin
        push_item          = '0;
        push_item.cls      = utf8c_pkg::CLS_BAD;
        push_item.rule     = utf8c_pkg::RULE_NONE;
        push_item.lead_len = 2'd0;
        push_item.ge_a0    = (b >= 8'hA0);
        push_item.ge_90    = (b >= 8'h90);
        push_item.le_8f    = (b <= 8'h8F);
        push_item.last     = bytes.end_of_payload;

        if (b == 8'h00)
        begin
            push_item.cls = utf8c_pkg::CLS_NUL;
        end
        else if (b == 8'h0D)
        begin
            push_item.cls = utf8c_pkg::CLS_CR;
        end
        else if ((b >= 8'h20 && b <= 8'h7E) || (b >= 8'h09 && b <= 8'h0C) || b == 8'h1B)
        begin
            push_item.cls = utf8c_pkg::CLS_TEXT;
        end
        else if (b >= 8'h80 && b <= 8'hBF)
        begin
            push_item.cls = utf8c_pkg::CLS_CONT;
        end
        else if (b >= 8'hC2 && b <= 8'hDF)
        begin
            push_item.cls      = utf8c_pkg::CLS_LEAD;
            push_item.lead_len = 2'd1;
        end
        else if (b >= 8'hE0 && b <= 8'hEF)
        begin
            push_item.cls      = utf8c_pkg::CLS_LEAD;
            push_item.lead_len = 2'd2;
            if (b == 8'hE0)
            begin
                push_item.rule = utf8c_pkg::RULE_MIN_A0;
            end
        end
        else if (b >= 8'hF0 && b <= 8'hF4)
        begin
            push_item.cls      = utf8c_pkg::CLS_LEAD;
            push_item.lead_len = 2'd3;
            if (b == 8'hF0)
            begin
                push_item.rule = utf8c_pkg::RULE_MIN_90;
            end
            else if (b == 8'hF4)
            begin
                push_item.rule = utf8c_pkg::RULE_MAX_8F;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/utf8c_queue.sv -----
// Short queue of classified bytes between the front and the back.
// Depends on utf8c_pkg.
`default_nettype none

module utf8c_queue #(
    parameter int Depth = utf8c_pkg::FIFO_DEPTH_DEFAULT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire utf8c_pkg::class_item_t push_item,
    output logic                        full,
    input  wire logic                   pop,
    output logic                        q_valid,
    output utf8c_pkg::class_item_t      q_item
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    utf8c_pkg::class_item_t entry_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign full    = (count_reg == CntW'(Depth));
    assign q_valid = (count_reg != '0);
    assign q_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/utf8c_back.sv -----
// Back end of the checker: runs the text/UTF-8 state and emits verdicts.
// Depends on utf8c_pkg and utf8c_verdict_if.
`default_nettype none

module utf8c_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   q_valid,
    input  wire utf8c_pkg::class_item_t q_item,
    output logic                        pop,
    utf8c_verdict_if.source             verdicts
);

    logic                    cr_seen_reg, cr_seen_next;
    logic                    utf8_seen_reg, utf8_seen_next;
    logic [1:0]              cont_left_reg, cont_left_next;
    utf8c_pkg::second_rule_t rule_reg, rule_next;
    logic                    rejected_reg, rejected_next;
    logic                    out_valid_reg, out_valid_next;
    logic [1:0]              verdict_reg, verdict_next;
    logic                    rule_ok;

    // A final byte needs a free output slot; other bytes drain freely.
    assign pop = q_valid && (!q_item.last || !out_valid_reg || verdicts.ready);

    assign verdicts.valid   = out_valid_reg;
    assign verdicts.verdict = verdict_reg;

    always_comb
    begin
        case (rule_reg)
            utf8c_pkg::RULE_MIN_A0: rule_ok = q_item.ge_a0;
            utf8c_pkg::RULE_MIN_90: rule_ok = q_item.ge_90;
            utf8c_pkg::RULE_MAX_8F: rule_ok = q_item.le_8f;
            default:                rule_ok = 1'b1;
        endcase
    end

    always_comb
    begin
        cr_seen_next   = cr_seen_reg;
        utf8_seen_next = utf8_seen_reg;
        cont_left_next = cont_left_reg;
        rule_next      = rule_reg;
        rejected_next  = rejected_reg;
        out_valid_next = out_valid_reg && !verdicts.ready;
        verdict_next   = verdict_reg;

        if (pop)
        begin
            if (rejected_reg)
            begin
                // Bytes after a violation are ignored until the final byte.
            end
            else if (cont_left_reg != 2'd0)
            begin
                if (q_item.cls != utf8c_pkg::CLS_CONT || !rule_ok)
                begin
                    rejected_next = 1'b1;
                end
                else
                begin
                    rule_next      = utf8c_pkg::RULE_NONE;
                    cont_left_next = cont_left_reg - 1'b1;
                    if (cont_left_reg == 2'd1)
                    begin
                        utf8_seen_next = 1'b1;
                    end
                end
            end
            else
            begin
                case (q_item.cls)
                    utf8c_pkg::CLS_NUL:
                    begin
                        if (cr_seen_reg)
                        begin
                            cr_seen_next = 1'b0;
                        end
                        else
                        begin
                            rejected_next = 1'b1;
                        end
                    end
                    utf8c_pkg::CLS_CR:
                    begin
                        cr_seen_next = 1'b1;
                    end
                    utf8c_pkg::CLS_TEXT:
                    begin
                        cr_seen_next = 1'b0;
                    end
                    utf8c_pkg::CLS_LEAD:
                    begin
                        cr_seen_next   = 1'b0;
                        cont_left_next = q_item.lead_len;
                        rule_next      = q_item.rule;
                    end
                    default:
                    begin
                        cr_seen_next  = 1'b0;
                        rejected_next = 1'b1;
                    end
                endcase
            end

            if (q_item.last)
            begin
                out_valid_next = 1'b1;
                if (rejected_next || cont_left_next != 2'd0)
                begin
                    verdict_next = utf8c_pkg::VERDICT_SUSPICIOUS;
                end
                else if (utf8_seen_next)
                begin
                    verdict_next = utf8c_pkg::VERDICT_UTF8;
                end
                else
                begin
                    verdict_next = utf8c_pkg::VERDICT_CLEAN;
                end
                cr_seen_next   = 1'b0;
                utf8_seen_next = 1'b0;
                cont_left_next = 2'd0;
                rule_next      = utf8c_pkg::RULE_NONE;
                rejected_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cr_seen_reg   <= 1'b0;
            utf8_seen_reg <= 1'b0;
            cont_left_reg <= 2'd0;
            rule_reg      <= utf8c_pkg::RULE_NONE;
            rejected_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cr_seen_reg   <= cr_seen_next;
            utf8_seen_reg <= utf8_seen_next;
            cont_left_reg <= cont_left_next;
            rule_reg      <= rule_next;
            rejected_reg  <= rejected_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        verdict_reg <= verdict_next;
    end

endmodule

`default_nettype wire

// ----- rtl/text_payload_utf8_checker.sv -----
// Top level of the text payload checker with UTF-8 validation.
// Depends on utf8c_pkg, utf8c_if, utf8c_front, utf8c_queue and utf8c_back.
//
//   Channel    Role     Payload                       Transfer
//   bytes      sink     text_byte[7:0], end_of_payload  valid && ready
//   verdicts   source   verdict[1:0]                  valid && ready
//
// The block takes one byte per cycle while the queue is not full. A byte is
// classified in the cycle of its transfer and written into a short queue;
// the back end takes one queued byte per cycle, except a final byte while a
// verdict is held, and updates the sequence state. The verdict for a final
// byte is loaded into the output register at the edge where that byte leaves
// the queue. Bytes that carry no end mark never wait on the output side.
// Reset is asynchronous and active low and leaves the queue empty, the state
// clear and no verdict pending. When a verdict is held and the next final
// byte reaches the head of the queue, the queue fills behind it and then
// holds off the byte source; at most one verdict is held.
`default_nettype none

module text_payload_utf8_checker #(
    parameter int FifoDepth = utf8c_pkg::FIFO_DEPTH_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    utf8c_byte_if.sink       bytes,
    utf8c_verdict_if.source  verdicts
);

    logic                   q_push;
    logic                   q_full;
    logic                   q_pop;
    logic                   q_valid;
    utf8c_pkg::class_item_t q_push_item;
    utf8c_pkg::class_item_t q_item;

    // Classification of each byte as it transfers in.
    utf8c_front u_front (
        .bytes     (bytes),
        .full      (q_full),
        .push      (q_push),
        .push_item (q_push_item)
    );

    // Decouples the byte source from verdict stalls.
    utf8c_queue #(
        .Depth (FifoDepth)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    // Sequence state, verdict computation and output register.
    utf8c_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .pop      (q_pop),
        .verdicts (verdicts)
    );

`ifndef SYNTHESIS
    // Only the three defined verdict codes are ever offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        verdicts.valid |-> (verdicts.verdict == utf8c_pkg::VERDICT_CLEAN ||
                            verdicts.verdict == utf8c_pkg::VERDICT_UTF8 ||
                            verdicts.verdict == utf8c_pkg::VERDICT_SUSPICIOUS))
        else $error("verdict code out of range");

    // A final byte never leaves the queue while a stalled verdict is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_item.last) |-> (!verdicts.valid || verdicts.ready))
        else $error("verdict overwritten while stalled");

    // Nothing is taken from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

    // A final byte taken from the queue shows up as a verdict next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_item.last) |=> verdicts.valid)
        else $error("final byte produced no verdict");
`endif

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// Testbench for text_payload_utf8_checker: directed and random byte payloads,
// with every verdict checked against a predictor of the text and UTF-8 rules.
// Depends on utf8c_pkg, utf8c_if and the RTL of the checker.
`timescale 1ns / 100ps

module tb;

    // Ends the run if the checker stops making progress.
    localparam int CYCLE_LIMIT = 200000;
    // Length of the long hold-off on the verdict side, which fills the queue.
    localparam int LONG_HOLD_CYCLES = 300;
    // Payload bytes sent per random phase.
    localparam int BYTES_PER_PHASE = 400;
    // Cycles allowed after the last verdict for anything stray to show up.
    localparam int DRAIN_CYCLES = 8;

    // The scoreboard tracks the payload state of the checker. Each accepted
    // byte runs through the same rules, and a final byte queues the verdict
    // that the checker must return for its payload.
    class verdict_scoreboard;
        logic                    cr_pending;
        logic                    utf8_done;
        logic [1:0]              cont_left;
        utf8c_pkg::second_rule_t rule;
        logic                    reject_latched;
        logic [1:0]              expected_verdicts[$];
        int                      errors;
        int                      live_bytes;

        function new();
            clear_payload();
            errors = 0;
            live_bytes = 0;
        endfunction

        function void clear_payload();
            cr_pending = 1'b0;
            utf8_done = 1'b0;
            cont_left = 2'd0;
            rule = utf8c_pkg::RULE_NONE;
            reject_latched = 1'b0;
        endfunction

        function bit second_ok(logic [7:0] b);
            case (rule)
                utf8c_pkg::RULE_MIN_A0: return b >= 8'hA0;
                utf8c_pkg::RULE_MIN_90: return b >= 8'h90;
                utf8c_pkg::RULE_MAX_8F: return b <= 8'h8F;
                default:                return 1'b1;
            endcase
        endfunction

        function void note_byte(logic [7:0] b, logic is_last);
            live_bytes++;
            if (!reject_latched)
            begin
                if (cont_left != 2'd0)
                begin
                    if (b[7:6] != 2'b10 || !second_ok(b))
                    begin
                        reject_latched = 1'b1;
                    end
                    else
                    begin
                        rule = utf8c_pkg::RULE_NONE;
                        cont_left = cont_left - 2'd1;
                        if (cont_left == 2'd0)
                        begin
                            utf8_done = 1'b1;
                        end
                    end
                end
                else if (b == 8'h00)
                begin
                    // A NUL passes only as the byte right after a CR.
                    if (cr_pending)
                    begin
                        cr_pending = 1'b0;
                    end
                    else
                    begin
                        reject_latched = 1'b1;
                    end
                end
                else
                begin
                    cr_pending = (b == 8'h0D);
                    if (b >= 8'h20 && b <= 8'h7E)
                    begin
                        // Printable ASCII.
                    end
                    else if (b == 8'h09 || b == 8'h0A || b == 8'h0B || b == 8'h0C ||
                             b == 8'h0D || b == 8'h1B)
                    begin
                        // Allowed control characters.
                    end
                    else if (b >= 8'hC2 && b <= 8'hDF)
                    begin
                        cont_left = 2'd1;
                        rule = utf8c_pkg::RULE_NONE;
                    end
                    else if (b >= 8'hE0 && b <= 8'hEF)
                    begin
                        cont_left = 2'd2;
                        rule = (b == 8'hE0) ? utf8c_pkg::RULE_MIN_A0 : utf8c_pkg::RULE_NONE;
                    end
                    else if (b >= 8'hF0 && b <= 8'hF4)
                    begin
                        cont_left = 2'd3;
                        if (b == 8'hF0)
                        begin
                            rule = utf8c_pkg::RULE_MIN_90;
                        end
                        else if (b == 8'hF4)
                        begin
                            rule = utf8c_pkg::RULE_MAX_8F;
                        end
                        else
                        begin
                            rule = utf8c_pkg::RULE_NONE;
                        end
                    end
                    else
                    begin
                        reject_latched = 1'b1;
                    end
                end
            end
            if (is_last)
            begin
                if (reject_latched || cont_left != 2'd0)
                begin
                    expected_verdicts.push_back(utf8c_pkg::VERDICT_SUSPICIOUS);
                end
                else if (utf8_done)
                begin
                    expected_verdicts.push_back(utf8c_pkg::VERDICT_UTF8);
                end
                else
                begin
                    expected_verdicts.push_back(utf8c_pkg::VERDICT_CLEAN);
                end
                clear_payload();
            end
        endfunction

        function void check_verdict(logic [1:0] actual);
            logic [1:0] wanted;
            if (expected_verdicts.size() == 0)
            begin
                $error("verdict: none expected, actual %0d", actual);
                errors++;
            end
            else
            begin
                wanted = expected_verdicts.pop_front();
                if (actual !== wanted)
                begin
                    $error("verdict: expected %0d, actual %0d", wanted, actual);
                    errors++;
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    utf8c_byte_if    byte_ch ();
    utf8c_verdict_if verdict_ch ();

    text_payload_utf8_checker dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .bytes    (byte_ch),
        .verdicts (verdict_ch)
    );

    verdict_scoreboard sb;

    // Idle rates in percent for the byte source and the verdict sink.
    int src_idle_pct;
    int sink_idle_pct;
    // Set by the stimulus at a rising edge, taken up by the sink at the next
    // falling edge, so the two processes never touch it in the same step.
    bit hold_request;
    int hold_left;
    int cycle_count;

    // Bytes of the payload being built for the next random transfer run.
    logic [7:0] payload_q[$];

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Both channels are observed at the rising edge, where the driven inputs
    // are stable since they only change at the falling edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_ch.valid && byte_ch.ready)
            begin
                sb.note_byte(byte_ch.text_byte, byte_ch.end_of_payload);
            end
            if (verdict_ch.valid && verdict_ch.ready)
            begin
                sb.check_verdict(verdict_ch.verdict);
            end
        end
    end

    // Verdict sink: either a counted long hold-off, or random stalls at the
    // current idle rate.
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_left = LONG_HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            verdict_ch.ready <= 1'b0;
        end
        else
        begin
            verdict_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // Offers one byte and returns at the falling edge after its transfer.
    // Must be called just after a falling edge. The valid stays high on
    // return, so back-to-back bytes go out with no gap unless the source idles.
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            @(negedge clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.text_byte <= b;
        byte_ch.end_of_payload <= is_last;
        do
        begin
            @(posedge clk);
        end
        while (!byte_ch.ready);
        @(negedge clk);
    endtask

    // Sends a short payload packed into a word, first byte in the highest
    // used lane.
    task automatic send_text(input logic [31:0] packed_bytes, input int count);
        for (int i = count - 1; i >= 0; i--)
        begin
            send_byte(packed_bytes[8 * i +: 8], i == 0);
        end
    endtask

    task automatic send_payload();
        for (int i = 0; i < payload_q.size(); i++)
        begin
            send_byte(payload_q[i], i == payload_q.size() - 1);
        end
    endtask

    // The source pauses until the checker has returned every verdict.
    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        while (sb.expected_verdicts.size() != 0)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Appends one UTF-8 sequence of two to four bytes, as the checker accepts it, with the
    // second-byte limits of the E0, F0 and F4 leads respected.
    function automatic void add_utf8_sequence();
        int         len;
        logic [7:0] lead;
        len = $urandom_range(2, 4);
        if (len == 2)
        begin
            lead = 8'($urandom_range(8'hC2, 8'hDF));
            payload_q.push_back(lead);
        end
        else if (len == 3)
        begin
            lead = 8'($urandom_range(8'hE0, 8'hEF));
            payload_q.push_back(lead);
            payload_q.push_back(8'((lead == 8'hE0) ? $urandom_range(8'hA0, 8'hBF)
                                                   : $urandom_range(8'h80, 8'hBF)));
        end
        else
        begin
            lead = 8'($urandom_range(8'hF0, 8'hF4));
            payload_q.push_back(lead);
            if (lead == 8'hF0)
            begin
                payload_q.push_back(8'($urandom_range(8'h90, 8'hBF)));
            end
            else if (lead == 8'hF4)
            begin
                payload_q.push_back(8'($urandom_range(8'h80, 8'h8F)));
            end
            else
            begin
                payload_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
            payload_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end
        payload_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
    endfunction

    // Appends plain text: mostly printable ASCII, some allowed controls, and
    // now and then a CR followed by a NUL.
    function automatic void add_text_piece();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            payload_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
        end
        else if (pick < 85)
        begin
            case ($urandom_range(0, 5))
                0: payload_q.push_back(8'h09);
                1: payload_q.push_back(8'h0A);
                2: payload_q.push_back(8'h0B);
                3: payload_q.push_back(8'h0C);
                4: payload_q.push_back(8'h0D);
                default: payload_q.push_back(8'h1B);
            endcase
        end
        else
        begin
            payload_q.push_back(8'h0D);
            payload_q.push_back(8'h00);
        end
    endfunction

    // Most payloads are well formed with random content, so that the
    // sequence state is exercised in depth. The rest carry a corrupted byte,
    // end in the middle of a sequence, or are pure noise.
    function automatic void build_payload();
        int kind;
        int pieces;
        kind = $urandom_range(0, 99);
        pieces = $urandom_range(1, 6);
        payload_q.delete();
        if (kind < 8)
        begin
            for (int i = 0; i < pieces; i++)
            begin
                payload_q.push_back(8'($urandom_range(0, 255)));
            end
        end
        else
        begin
            for (int i = 0; i < pieces; i++)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    add_utf8_sequence();
                end
                else
                begin
                    add_text_piece();
                end
            end
            if (kind < 18)
            begin
                payload_q[$urandom_range(0, payload_q.size() - 1)] = 8'($urandom_range(0, 255));
            end
            else if (kind < 24)
            begin
                // Lead byte with its sequence cut off by the end mark.
                payload_q.push_back(8'($urandom_range(8'hC2, 8'hF4)));
            end
        end
    endfunction

    initial
    begin
        sb = new();
        src_idle_pct = 28;
        sink_idle_pct = 45;
        hold_request = 1'b0;
        hold_left = 0;
        cycle_count = 0;
        rst_n = 1'b0;
        byte_ch.valid = 1'b0;
        byte_ch.text_byte = 8'h00;
        byte_ch.end_of_payload = 1'b0;
        verdict_ch.ready = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed payloads: the low end of the text range, DEL, a lone NUL, CR
        // then NUL, a two-byte character, the E0 and F4 second-byte limits, a
        // surrogate that passes, a cut sequence, a NUL after a sequence that
        // followed a CR, a NUL inside a sequence, bad leads and a stray continuation.
        send_text(32'h20, 1);
        send_text(32'h7F, 1);
        send_text(32'h00, 1);
        send_text(32'h0D00, 2);
        send_text(32'hC280, 2);
        send_text(32'hE09F41, 3);
        send_text(32'hF490, 2);
        send_text(32'hEDA0BF, 3);
        send_text(32'hDF, 1);
        send_text(32'h0DC28000, 4);
        send_text(32'hC200, 2);
        send_text(32'hFF, 1);
        send_text(32'hC1, 1);
        send_text(32'h80, 1);
        wait_drained();

        // Three random phases: the sink is stalled more than the source idles,
        // then the other way round, then no idling at all. The last phase
        // opens with a long sink hold-off while the source keeps offering
        // bytes, so the queue fills and the byte channel is held off.
        for (int phase = 0; phase < 3; phase++)
        begin
            if (phase == 1)
            begin
                src_idle_pct = 45;
                sink_idle_pct = 28;
            end
            else if (phase == 2)
            begin
                src_idle_pct = 0;
                sink_idle_pct = 0;
                @(posedge clk);
                hold_request = 1'b1;
                @(negedge clk);
            end
            while (sb.live_bytes < 25 + (phase + 1) * BYTES_PER_PHASE)
            begin
                build_payload();
                send_payload();
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.expected_verdicts.size() == 0)
        begin
            $display("tb: done, clean");
        end
        else
        begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
